### rtl/assert_macros.svh
// Assertion helpers used by the line index offset locator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: always property");

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/lioloc_pkg.sv
package lioloc_pkg;

  // Item kinds carried on in_tuser
  localparam logic [1:0] OP_APPEND  = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;

  // Field widths
  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int QOFF_W   = 16;
  localparam int LINE_W   = 10;
  localparam int COL_W    = 16;

  // Word layouts
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

endpackage

### rtl/line_index_offset_locator.sv
// Channel | Dir | tdata (low bit up)                      | tuser
// --------+-----+-----------------------------------------+----------
// in_     | in  | data_byte[7:0], query_offset[23:8]      | op[1:0]
// out_    | out | line_number[9:0], column_number[25:10], | -
//         |     | overflow[26], zero pad[31:27]           |
//
// Append and restart words need no result slot and leave the block ready for the next word.
// A query runs S binary search steps over the line starts, S about
// ceil(log2(line count)) and so at most ceil(log2(MAX_LINES)), then forms its
// result; the line start RAM's single read port (one table read per cycle) paces it.
// rst_n is synchronous, active low; the table RAM is not cleared, line 0
// always starts at offset 0 and its start is never taken from the RAM.
// A query stalls in its last cycle while the previous result waits on out_tready.
`include "assert_macros.svh"

module line_index_offset_locator
  import lioloc_pkg::*;
#(
  parameter int MAX_LINES   = 1024,
  parameter int OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // slave side
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // data_byte[7:0], query_offset[23:8]
  input  logic [OP_W-1:0]        in_tuser,   // op[1:0]
  // master side
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // line_number[9:0], column_number[25:10],
                                             // overflow[26]
);

  // Index widths: LW addresses the table, CW also holds MAX_LINES itself
  localparam int LW    = $clog2(MAX_LINES);
  localparam int CW    = $clog2(MAX_LINES + 1);
  localparam int PW    = OFFSET_BITS + 1;
  localparam int CMP_W = (OFFSET_BITS > QOFF_W) ? OFFSET_BITS : QOFF_W;

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LINES);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SRCH = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    line_cnt_r, line_cnt_nxt;
  logic [PW-1:0]    byte_pos_r, byte_pos_nxt;
  logic             dropped_r, dropped_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Search working registers
  logic [LW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [LW-1:0]    mid_r, mid_nxt;
  logic [CMP_W-1:0] qoff_r, qoff_nxt;

  // Result payload
  logic [LINE_W-1:0] line_out_r, line_out_nxt;
  logic [COL_W-1:0]  col_out_r, col_out_nxt;
  logic              ovf_out_r, ovf_out_nxt;

  // RAM ports
  logic                   ram_we;
  logic [LW-1:0]          ram_waddr;
  logic [OFFSET_BITS-1:0] ram_wdata;
  logic                   ram_re;
  logic [LW-1:0]          ram_raddr;
  logic [OFFSET_BITS-1:0] ram_rdata;

  // Input fields
  logic [OP_W-1:0]   in_op;
  logic [BYTE_W-1:0] in_byte;
  logic [QOFF_W-1:0] in_qoff;
  logic              in_acc;

  // Datapath helpers
  logic [PW-1:0]    pos_inc;
  logic [CMP_W-1:0] start_ext;
  logic             start_le;
  logic [LW-1:0]    lo_step;
  logic [CW-1:0]    hi_step;
  logic [CW-1:0]    span;
  logic [CMP_W-1:0] fin_start;
  logic [CMP_W-1:0] col_full;
  logic             fin_go;

  assign in_op   = in_tuser;
  assign in_byte = in_tdata[BYTE_W-1:0];
  assign in_qoff = in_tdata[BYTE_W +: QOFF_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign pos_inc = byte_pos_r + PW'(1);

  // One search step: keep the lower half when the probed start lies above the offset
  assign start_ext = CMP_W'(ram_rdata);
  assign start_le  = (start_ext <= qoff_r);
  assign lo_step   = start_le ? mid_r : lo_r;
  assign hi_step   = start_le ? hi_r : CW'(mid_r);
  assign span      = hi_step - CW'(lo_step);

  // Line 0 always starts at offset 0
  assign fin_start = (lo_r == '0) ? '0 : start_ext;
  assign col_full  = qoff_r - fin_start;
  assign fin_go    = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt     = state_r;
    line_cnt_nxt  = line_cnt_r;
    byte_pos_nxt  = byte_pos_r;
    dropped_nxt   = dropped_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    qoff_nxt      = qoff_r;
    line_out_nxt  = line_out_r;
    col_out_nxt   = col_out_r;
    ovf_out_nxt   = ovf_out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = line_cnt_r[LW-1:0];
    ram_wdata     = pos_inc[OFFSET_BITS-1:0];
    ram_re        = 1'b0;
    ram_raddr     = mid_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_op)
            OP_APPEND: begin
              if (byte_pos_r[OFFSET_BITS]) begin
                // position space exhausted: drop the byte
                dropped_nxt = 1'b1;
              end else begin
                if (in_byte == NEWLINE_CHAR) begin
                  if ((line_cnt_r < MAX_CNT) && !pos_inc[OFFSET_BITS]) begin
                    ram_we       = 1'b1;
                    line_cnt_nxt = line_cnt_r + CW'(1);
                  end else begin
                    dropped_nxt = 1'b1;
                  end
                end
                byte_pos_nxt = pos_inc;
              end
            end
            OP_QUERY: begin
              lo_nxt   = '0;
              hi_nxt   = line_cnt_r;
              qoff_nxt = CMP_W'(in_qoff);
              mid_nxt  = LW'(line_cnt_r >> 1);
              if (line_cnt_r > CW'(1)) begin
                ram_re    = 1'b1;
                ram_raddr = LW'(line_cnt_r >> 1);
                state_nxt = ST_SRCH;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            OP_RESTART: begin
              line_cnt_nxt = CW'(1);
              byte_pos_nxt = '0;
              dropped_nxt  = 1'b0;
            end
            default: begin
              // unused code: drop the word
            end
          endcase
        end
      end
      ST_SRCH: begin
        lo_nxt  = lo_step;
        hi_nxt  = hi_step;
        ram_re  = 1'b1;
        if (span > CW'(1)) begin
          mid_nxt   = LW'(CW'(lo_step) + (span >> 1));
          ram_raddr = LW'(CW'(lo_step) + (span >> 1));
        end else begin
          // converged: fetch the start of the chosen line
          ram_raddr = lo_step;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          line_out_nxt  = LINE_W'(lo_r);
          col_out_nxt   = col_full[COL_W-1:0];
          ovf_out_nxt   = dropped_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_cnt_r  <= CW'(1);
      byte_pos_r  <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_cnt_r  <= line_cnt_nxt;
      byte_pos_r  <= byte_pos_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    qoff_r     <= qoff_nxt;
    line_out_r <= line_out_nxt;
    col_out_r  <= col_out_nxt;
    ovf_out_r  <= ovf_out_nxt;
  end

  lioloc_ram #(
    .WIDTH(OFFSET_BITS),
    .DEPTH(MAX_LINES)
  ) u_line_starts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - LINE_W - COL_W - 1)'(0), ovf_out_r, col_out_r,
                       line_out_r};

  // A query holds off the next word until its result is loaded
  `ASSERT_NEXT(a_query_blocks, clk, rst_n,
    in_tvalid && in_tready && (in_tuser == OP_QUERY), !in_tready)
  // The table always holds line 0 and never more than its depth
  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n,
    (line_cnt_r != '0) && (line_cnt_r <= MAX_CNT))
  // While searching, the window still spans more than one line
  `ASSERT_SAME(a_srch_window, clk, rst_n,
    state_r == ST_SRCH, (hi_r > CW'(lo_r)) && ((hi_r - CW'(lo_r)) > CW'(1)))
  // A result appears only out of the finish state (ST_FIN)
  `ASSERT_SAME(a_out_from_fin, clk, rst_n,
    $rose(out_valid_r), $past(state_r) == ST_FIN)

endmodule

### rtl/lioloc_ram.sv
module lioloc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
